[hdl/dsk_pkg.sv]
// Shared types and constants for the decade scan keyboard emulator.
// No dependencies; used by every module of the block.
`default_nettype none

package dsk_pkg;

    localparam logic [3:0] LastColumn   = 4'd9;
    localparam logic [3:0] ScansDefault = 4'd4;

    // Register indexes on the configuration port
    localparam logic [0:0] RegScansPerKey = 1'b0;

    // One input item
    typedef struct packed {
        logic       kind;
        logic       ram_line;
        logic       rst_line;
        logic       clk_line;
        logic [1:0] key_row;
        logic [3:0] key_column;
        logic       key_shift;
        logic       key_func;
    } t_item;

    // One result item
    typedef struct packed {
        logic [3:0] row_lines;
        logic       shift_out;
        logic       func_out;
        logic [3:0] column_now;
        logic       busy_res;
    } t_result;

endpackage

`default_nettype wire

[hdl/decade_scan_keyboard_emulator_core.sv]
// Decade scan keyboard emulator. Each transferred item is either a pin sample from the
// host port (RAM-disable, counter reset, counter clock) or a key press request; every item
// yields exactly one result with the row drive levels, shift and func lines, the emulated
// column counter and a busy flag. The block takes one item per clock while input ready is
// high: the counter and key sequence state update on the transfer, and the result is
// registered in the output buffer. A two-entry output buffer keeps the input ready for
// one more item while the output is stalled; input ready drops only when both entries are
// full. scans_per_key (APB offset 0, reset 4) sets how many column scans a key is held.
`default_nettype none

module decade_scan_keyboard_emulator_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // input items
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_kind,
    input  wire logic        i_ram_line,
    input  wire logic        i_rst_line,
    input  wire logic        i_clk_line,
    input  wire logic [1:0]  i_key_row,
    input  wire logic [3:0]  i_key_column,
    input  wire logic        i_key_shift,
    input  wire logic        i_key_func,
    // results
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [3:0]       o_row_lines,
    output logic             o_shift_out,
    output logic             o_func_out,
    output logic [3:0]       o_column_now,
    output logic             o_busy_res
);

    logic             in_xfer;
    logic [3:0]       scans_per_key;
    dsk_pkg::t_item   item;
    dsk_pkg::t_result step_result;
    dsk_pkg::t_result out_result;

    dsk_apb_regs u_regs (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_scans_per_key (scans_per_key)
    );

    assign item.kind       = i_kind;
    assign item.ram_line   = i_ram_line;
    assign item.rst_line   = i_rst_line;
    assign item.clk_line   = i_clk_line;
    assign item.key_row    = i_key_row;
    assign item.key_column = i_key_column;
    assign item.key_shift  = i_key_shift;
    assign item.key_func   = i_key_func;

    assign in_xfer = i_in_valid & o_in_ready;

    dsk_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_xfer),
        .i_item          (item),
        .i_scans_per_key (scans_per_key),
        .o_result        (step_result)
    );

    dsk_out_buf u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (in_xfer),
        .i_result   (step_result),
        .o_can_push (o_in_ready),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_result   (out_result)
    );

    assign o_row_lines  = out_result.row_lines;
    assign o_shift_out  = out_result.shift_out;
    assign o_func_out   = out_result.func_out;
    assign o_column_now = out_result.column_now;
    assign o_busy_res   = out_result.busy_res;

endmodule

`default_nettype wire

[hdl/dsk_apb_regs.sv]
// APB-style configuration register file: holds scans_per_key.
// Depends on dsk_pkg for the reset value and register index.
`default_nettype none

module dsk_apb_regs (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output logic [3:0]       o_scans_per_key
);

    logic [3:0] r_scans_per_key;
    logic       wr_en;
    logic [0:0] reg_index;

    // One 32-bit register: the index is tied to RegScansPerKey, so a write at any paddr updates it
    assign reg_index = 1'b0;
    assign wr_en     = psel & penable & pwrite & pready;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scans_per_key <= dsk_pkg::ScansDefault;
        end else if (wr_en && reg_index == dsk_pkg::RegScansPerKey) begin
            r_scans_per_key <= pwdata[3:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_index == dsk_pkg::RegScansPerKey && paddr[1:0] == 2'b00) begin
            prdata = {28'd0, r_scans_per_key};
        end
    end

    assign o_scans_per_key = r_scans_per_key;

endmodule

`default_nettype wire

[hdl/dsk_seq.sv]
// Column counter tracking and key sequence state machine; computes one result per item.
// Depends on dsk_pkg for the item and result types.
`default_nettype none

module dsk_seq (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire dsk_pkg::t_item   i_item,
    input  wire logic [3:0]       i_scans_per_key,
    output dsk_pkg::t_result      o_result
);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_SEEK = 2'd1,
        PH_HOLD = 2'd2
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [3:0] r_column_count, n_column_count;
    logic       r_last_rst, n_last_rst;
    logic       r_last_clk, n_last_clk;
    logic [3:0] r_scans_done, n_scans_done;
    logic [1:0] r_held_row, n_held_row;
    logic [3:0] r_held_column, n_held_column;
    logic [1:0] r_held_mods, n_held_mods;

    logic [3:0] limit;
    logic [3:0] scans_inc;
    logic       active;

    always_comb begin
        n_phase        = r_phase;
        n_column_count = r_column_count;
        n_last_rst     = r_last_rst;
        n_last_clk     = r_last_clk;
        n_scans_done   = r_scans_done;
        n_held_row     = r_held_row;
        n_held_column  = r_held_column;
        n_held_mods    = r_held_mods;
        limit          = (i_scans_per_key == 4'd0) ? 4'd1 : i_scans_per_key;
        scans_inc      = r_scans_done + 4'd1;

        if (!i_item.kind) begin
            // Counter first; the sequence step sees the updated count
            n_last_rst = i_item.rst_line;
            n_last_clk = i_item.clk_line;
            if (!r_last_rst && i_item.rst_line && i_item.ram_line) begin
                n_column_count = '0;
            end
            if (!r_last_clk && i_item.clk_line && !i_item.rst_line) begin
                n_column_count = (n_column_count == dsk_pkg::LastColumn) ?
                                 4'd0 : n_column_count + 4'd1;
            end

            unique case (r_phase)
                PH_IDLE: begin
                    n_phase = PH_IDLE;
                end
                PH_SEEK: begin
                    if (n_column_count == r_held_column) begin
                        n_phase = PH_HOLD;
                    end
                end
                PH_HOLD: begin
                    // Release the row at the end of the scan
                    if (i_item.rst_line && i_item.ram_line) begin
                        if (scans_inc == 4'd0 || scans_inc >= limit) begin
                            n_phase      = PH_IDLE;
                            n_scans_done = '0;
                        end else begin
                            n_phase      = PH_SEEK;
                            n_scans_done = scans_inc;
                        end
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end else if (r_phase == PH_IDLE && i_item.key_column <= dsk_pkg::LastColumn) begin
            // Latch the key; presses while busy or off the matrix drop
            n_held_row    = i_item.key_row;
            n_held_column = i_item.key_column;
            n_held_mods   = {i_item.key_func, i_item.key_shift};
            n_scans_done  = '0;
            n_phase       = PH_SEEK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_column_count <= '0;
            r_last_rst     <= 1'b0;
            r_last_clk     <= 1'b0;
            r_scans_done   <= '0;
            r_held_row     <= '0;
            r_held_column  <= '0;
            r_held_mods    <= '0;
        end else if (i_accept) begin
            r_phase        <= n_phase;
            r_column_count <= n_column_count;
            r_last_rst     <= n_last_rst;
            r_last_clk     <= n_last_clk;
            r_scans_done   <= n_scans_done;
            r_held_row     <= n_held_row;
            r_held_column  <= n_held_column;
            r_held_mods    <= n_held_mods;
        end
    end

    always_comb begin
        active              = (n_phase == PH_SEEK) || (n_phase == PH_HOLD);
        o_result.row_lines  = (n_phase == PH_HOLD) ? ~(4'b0001 << n_held_row) : 4'hF;
        o_result.shift_out  = active & n_held_mods[0];
        o_result.func_out   = active & n_held_mods[1];
        o_result.column_now = n_column_count;
        o_result.busy_res   = active;
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_column_count <= dsk_pkg::LastColumn)
        else $error("column counter left the decade range");

    a_key_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_item.kind && r_phase == PH_IDLE &&
        i_item.key_column <= dsk_pkg::LastColumn |=> r_phase == PH_SEEK)
        else $error("accepted key press did not start the sequence");

    a_busy_holds_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_item.kind && r_phase != PH_IDLE |=> $stable(r_held_column))
        else $error("key press while busy changed the held key");

    a_scans_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> r_scans_done == 4'd0)
        else $error("scan count not cleared while idle");

endmodule

`default_nettype wire

[hdl/dsk_out_buf.sv]
// Two-entry result buffer: output register plus skid stage, so input keeps flowing.
// Depends on dsk_pkg for the result type.
`default_nettype none

module dsk_out_buf (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire dsk_pkg::t_result  i_result,
    output logic                   o_can_push,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output dsk_pkg::t_result       o_result
);

    logic             r_out_valid;
    logic             r_skid_valid;
    dsk_pkg::t_result r_out;
    dsk_pkg::t_result r_skid;

    assign o_can_push = ~r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_ready || !r_out_valid) begin
            r_out_valid  <= r_skid_valid | i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ready || !r_out_valid) begin
            r_out <= r_skid_valid ? r_skid : i_result;
        end else if (i_push) begin
            r_skid <= i_result;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without an output entry");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && !i_ready |=> r_skid_valid && $stable(r_skid))
        else $error("skid entry lost while output stalled");

    a_drain_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && i_ready |=> r_out_valid && r_out == $past(r_skid))
        else $error("skid entry not moved to output");

endmodule

`default_nettype wire
